// File: hdl/sst_pkg.sv
// Package: shared constants, tables and widths for the steered sonar trigger and echo block.
`default_nettype none
package sst_pkg;

  localparam int unsigned NUM_SONARS_DEF      = 2;
  localparam int unsigned MIN_PULSE_TICKS_DEF = 25;
  localparam int unsigned ECHO_COUNT_BITS_DEF = 16;

  localparam int unsigned ANGLE_W = 6;
  localparam int unsigned CHAN_W  = 2;
  localparam int unsigned DIST_W  = 14;
  localparam int unsigned DELAY_W = 7;
  localparam int unsigned MAG_W   = 6;

  localparam int unsigned DELAY_MAX = 68;
  localparam logic [DIST_W-1:0] DIST_MAX = 14'd16383;

  // floor(175*t/1000) = floor(floor(7t/8)/5); t at or above the limit saturates
  localparam int unsigned T_EXT_W  = 25;
  localparam logic [T_EXT_W-1:0] DIST_SAT_T = 25'd93623;
  localparam int unsigned DIV5_MUL = 52429;
  localparam int unsigned DIV5_SHR = 18;

  // round(128.5714 * sin(|angle| deg)), |angle| = 0..32
  localparam logic [DELAY_W-1:0] STEER_DELAY [33] = '{
    7'd0,  7'd2,  7'd4,  7'd7,  7'd9,  7'd11, 7'd13, 7'd16, 7'd18, 7'd20, 7'd22,
    7'd25, 7'd27, 7'd29, 7'd31, 7'd33, 7'd35, 7'd38, 7'd40, 7'd42, 7'd44, 7'd46,
    7'd48, 7'd50, 7'd52, 7'd54, 7'd56, 7'd58, 7'd60, 7'd62, 7'd64, 7'd66, 7'd68
  };

endpackage
`default_nettype wire

// File: hdl/sst_if.sv
// Interfaces: tick request channel and tick result channel.
`default_nettype none
interface sst_req_if;
  logic                        valid;
  logic                        ready;
  logic                        start_request;
  logic [sst_pkg::CHAN_W-1:0]  echo_levels;

  modport source (output valid, output start_request, output echo_levels, input ready);
  modport sink   (input valid, input start_request, input echo_levels, output ready);
endinterface

interface sst_res_if;
  logic                        valid;
  logic                        ready;
  logic [sst_pkg::CHAN_W-1:0]  trigger_levels;
  logic                        busy_res;
  logic [sst_pkg::CHAN_W-1:0]  distance_valid_mask;
  logic [sst_pkg::DIST_W-1:0]  distance_first_mm;
  logic [sst_pkg::DIST_W-1:0]  distance_second_mm;

  modport source (output valid, output trigger_levels, output busy_res,
                  output distance_valid_mask, output distance_first_mm,
                  output distance_second_mm, input ready);
  modport sink   (input valid, input trigger_levels, input busy_res,
                  input distance_valid_mask, input distance_first_mm,
                  input distance_second_mm, output ready);
endinterface
`default_nettype wire

// File: hdl/steered_sonar_trigger_and_echo.sv
// Top level: steered sonar trigger sequencer and echo pulse timer.
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+----------------------------------------------
//   cfg      | in  | cfg_we_i     | cfg_wdata_i = steering_angle_deg
//   req_i    | in  | valid/ready  | start_request, echo_levels
//   res_o    | out | valid/ready  | trigger_levels, busy_res, distance_valid_mask,
//            |     |              | distance_first_mm, distance_second_mm
//
// One item per cycle unless res_o stalls; its result sits in res_q the cycle after acceptance.
// All sequencing and echo state updates in the cycle an item is accepted.
// req_i.ready is low only while a result waits and res_o.ready is low.
// rst_ni clears all state but res_q: idle, triggers low, counters and distances zero.
`default_nettype none
module steered_sonar_trigger_and_echo #(
  parameter int unsigned NUM_SONARS      = sst_pkg::NUM_SONARS_DEF,
  parameter int unsigned MIN_PULSE_TICKS = sst_pkg::MIN_PULSE_TICKS_DEF,
  parameter int unsigned ECHO_COUNT_BITS = sst_pkg::ECHO_COUNT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sst_pkg::ANGLE_W-1:0] cfg_wdata_i,
  sst_req_if.sink                     req_i,
  sst_res_if.source                   res_o
);

  localparam int unsigned TickW =
    $clog2(MIN_PULSE_TICKS + 2 * (NUM_SONARS - 1) * sst_pkg::DELAY_MAX + 2);
  localparam int unsigned ChanN = sst_pkg::CHAN_W;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_QUIET  = 3'b010,
    PH_ACTIVE = 3'b100
  } phase_e;

  typedef struct packed {
    logic [sst_pkg::CHAN_W-1:0] trig;
    logic                       busy;
    logic [sst_pkg::CHAN_W-1:0] mask;
    logic [sst_pkg::DIST_W-1:0] dist0;
    logic [sst_pkg::DIST_W-1:0] dist1;
  } res_t;

  function automatic logic [sst_pkg::DIST_W-1:0] dist_calc(
    input logic [ECHO_COUNT_BITS-1:0] t
  );
    logic [sst_pkg::T_EXT_W-1:0] te;
    logic [27:0]                 t7;
    logic [16:0]                 x;
    logic [33:0]                 prod;
    te   = sst_pkg::T_EXT_W'(t);
    t7   = (28'(te) << 3) - 28'(te);
    x    = t7[19:3];
    prod = 34'(x) * 34'(sst_pkg::DIV5_MUL);
    if (te >= sst_pkg::DIST_SAT_T) begin
      dist_calc = sst_pkg::DIST_MAX;
    end else begin
      dist_calc = prod[sst_pkg::DIV5_SHR +: sst_pkg::DIST_W];
    end
  endfunction

  logic [sst_pkg::ANGLE_W-1:0] angle_q;
  phase_e                      phase_q, phase_d, phase_s;
  logic [TickW-1:0]            ticks_q, ticks_d, ticks_s;
  logic [sst_pkg::DELAY_W-1:0] delay_q, delay_s;
  logic                        order_q, order_s;
  logic [ChanN-1:0]            echo_prev_q;
  logic [ECHO_COUNT_BITS-1:0]  cnt_q [ChanN];
  logic [ECHO_COUNT_BITS-1:0]  cnt_d [ChanN];
  logic [sst_pkg::DIST_W-1:0]  dist_q [ChanN];
  logic [sst_pkg::DIST_W-1:0]  dist_d [ChanN];
  logic                        res_valid_q;
  res_t                        res_q, res_d;

  logic                        accept;
  logic                        start_c;
  logic [sst_pkg::MAG_W-1:0]   mag_c;
  logic [TickW-1:0]            span_c, wid_c, total_c, tick_inc;
  logic [TickW-1:0]            on_c [NUM_SONARS];
  logic [NUM_SONARS-1:0]       trig_c;
  logic [ChanN-1:0]            fall_c;

  assign req_i.ready = !res_valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign mag_c   = angle_q[sst_pkg::ANGLE_W-1]
                 ? sst_pkg::MAG_W'(7'd64 - {1'b0, angle_q}) : angle_q;
  assign start_c = (phase_q == PH_IDLE) && req_i.start_request;
  assign phase_s = start_c ? PH_QUIET : phase_q;
  assign ticks_s = start_c ? '0 : ticks_q;
  assign delay_s = start_c ? sst_pkg::STEER_DELAY[mag_c] : delay_q;
  assign order_s = start_c ? angle_q[sst_pkg::ANGLE_W-1] : order_q;

  assign span_c   = TickW'(NUM_SONARS - 1) * TickW'(delay_s);
  assign wid_c    = (span_c + TickW'(1) > TickW'(MIN_PULSE_TICKS))
                  ? span_c + TickW'(1) : TickW'(MIN_PULSE_TICKS);
  assign total_c  = wid_c + span_c;
  assign tick_inc = ticks_s + TickW'(1);

  always_comb begin
    for (int k = 0; k < NUM_SONARS; k++) begin
      on_c[k]   = order_s ? TickW'(NUM_SONARS - 1 - k) * TickW'(delay_s)
                          : TickW'(k) * TickW'(delay_s);
      trig_c[k] = (phase_s == PH_ACTIVE) && (ticks_s >= on_c[k])
               && (ticks_s < on_c[k] + wid_c);
    end
  end

  always_comb begin
    phase_d = phase_s;
    ticks_d = ticks_s;
    case (phase_s)
      PH_IDLE: begin
        ticks_d = ticks_s;
      end
      PH_QUIET: begin
        if (tick_inc >= TickW'(MIN_PULSE_TICKS)) begin
          phase_d = PH_ACTIVE;
          ticks_d = '0;
        end else begin
          ticks_d = tick_inc;
        end
      end
      PH_ACTIVE: begin
        if (tick_inc >= total_c) begin
          phase_d = PH_IDLE;
          ticks_d = '0;
        end else begin
          ticks_d = tick_inc;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        ticks_d = '0;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < ChanN; k++) begin
      cnt_d[k]  = cnt_q[k];
      dist_d[k] = dist_q[k];
      fall_c[k] = 1'b0;
      if (req_i.echo_levels[k]) begin
        if (!echo_prev_q[k]) begin
          cnt_d[k] = ECHO_COUNT_BITS'(1);
        end else if (cnt_q[k] != '1) begin
          cnt_d[k] = cnt_q[k] + ECHO_COUNT_BITS'(1);
        end
      end else if (echo_prev_q[k]) begin
        dist_d[k] = dist_calc(cnt_q[k]);
        cnt_d[k]  = '0;
        fall_c[k] = 1'b1;
      end
    end
  end

  always_comb begin
    res_d.trig  = trig_c[ChanN-1:0];
    res_d.busy  = (phase_s != PH_IDLE);
    res_d.mask  = fall_c;
    res_d.dist0 = dist_d[0];
    res_d.dist1 = dist_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
    end else if (cfg_we_i) begin
      angle_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      ticks_q     <= '0;
      delay_q     <= '0;
      order_q     <= 1'b0;
      echo_prev_q <= '0;
      for (int k = 0; k < ChanN; k++) begin
        cnt_q[k]  <= '0;
        dist_q[k] <= '0;
      end
    end else if (accept) begin
      phase_q     <= phase_d;
      ticks_q     <= ticks_d;
      delay_q     <= delay_s;
      order_q     <= order_s;
      echo_prev_q <= req_i.echo_levels;
      for (int k = 0; k < ChanN; k++) begin
        cnt_q[k]  <= cnt_d[k];
        dist_q[k] <= dist_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid               = res_valid_q;
  assign res_o.trigger_levels      = res_q.trig;
  assign res_o.busy_res            = res_q.busy;
  assign res_o.distance_valid_mask = res_q.mask;
  assign res_o.distance_first_mm   = res_q.dist0;
  assign res_o.distance_second_mm  = res_q.dist1;

endmodule
`default_nettype wire

// File: hdl/sst_checker.sv
// Checker: port-level assertions for the sonar block, bound to the top level.
`default_nettype none
module sst_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  logic                       req_ready_i,
  input  logic                       res_valid_i,
  input  logic                       res_ready_i,
  input  logic [sst_pkg::CHAN_W-1:0] res_trig_i,
  input  logic                       res_busy_i,
  input  logic [sst_pkg::CHAN_W-1:0] res_mask_i,
  input  logic [sst_pkg::DIST_W-1:0] res_dist0_i,
  input  logic [sst_pkg::DIST_W-1:0] res_dist1_i
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_trig_i)
      && $stable(res_busy_i) && $stable(res_mask_i)
      && $stable(res_dist0_i) && $stable(res_dist1_i))
    else $error("result changed while stalled");

  // no trigger while the result is not busy
  a_trig_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_trig_i != '0) |-> res_busy_i)
    else $error("trigger high while not busy");

  // empty output register never blocks input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i |-> req_ready_i)
    else $error("input stalled with empty output");

  // an accepted item always yields a result next cycle
  a_res_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> res_valid_i)
    else $error("accepted item produced no result");

endmodule

bind steered_sonar_trigger_and_echo sst_checker u_sst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_trig_i  (res_o.trigger_levels),
  .res_busy_i  (res_o.busy_res),
  .res_mask_i  (res_o.distance_valid_mask),
  .res_dist0_i (res_o.distance_first_mm),
  .res_dist1_i (res_o.distance_second_mm)
);
`default_nettype wire
